@@ hdl/jfo_pkg.sv @@
// shared types, constants and arithmetic helpers for the joint friction observer
`default_nettype none
package jfo_pkg;

   localparam int JOINT_COUNT = 6;
   localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam int STATE_W = 128;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // register indexes
   localparam logic [2:0] REG_RATE_GAIN  = 3'd0;
   localparam logic [2:0] REG_POS_GAIN   = 3'd1;
   localparam logic [2:0] REG_STEP_INERT = 3'd2;
   localparam logic [2:0] REG_TIME_STEP  = 3'd3;
   localparam logic [2:0] REG_ALPHA_STEP = 3'd4;
   localparam logic [2:0] REG_ALPHA_FIN  = 3'd5;
   localparam logic [2:0] REG_TORQ_COEFF = 3'd6;
   localparam logic [2:0] REG_RAMP_TICKS = 3'd7;

   // ramp phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RAMP = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   typedef struct packed {
      logic [30:0] rate_error_gain;
      logic [30:0] position_error_gain;
      logic [30:0] step_over_inertia;
      logic [30:0] time_step;
      logic [30:0] friction_alpha_step;
      logic [30:0] friction_alpha_final;
      logic [30:0] torque_filter_coeff;
      logic [15:0] ramp_ticks;
   } cfg_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [JIDX_W-1:0] addr;
      logic [STATE_W-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] ramp_phase;
   } stat_type;

   function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
      return 66'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -66'sh8000_0000) r = -32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
      return (x + 66'sd32768) >>> 16;
   endfunction

   function automatic logic signed [65:0] rnd30(input logic signed [65:0] x);
      return (x + 66'sd536870912) >>> 30;
   endfunction

   function automatic logic [30:0] clamp_q30(input logic [30:0] c);
      return (c > Q30_ONE) ? Q30_ONE : c;
   endfunction

endpackage
`default_nettype wire

@@ hdl/jfo_req_if.sv @@
// request and response channel interfaces
`default_nettype none
interface jfo_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         joint_index;
   logic signed [31:0] measured_angle;
   logic signed [31:0] measured_velocity;
   logic signed [31:0] commanded_torque;
   logic signed [31:0] sensed_torque;
   logic               resync;
   modport source (output valid, joint_index, measured_angle, measured_velocity,
                   commanded_torque, sensed_torque, resync, input ready);
   modport sink (input valid, joint_index, measured_angle, measured_velocity,
                 commanded_torque, sensed_torque, resync, output ready);
endinterface

interface jfo_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         joint_echo;
   logic signed [31:0] friction_torque;
   logic signed [31:0] filtered_torque;
   logic               ramp_done;
   modport source (output valid, joint_echo, friction_torque, filtered_torque,
                   ramp_done, input ready);
   modport sink (input valid, joint_echo, friction_torque, filtered_torque,
                 ramp_done, output ready);
endinterface
`default_nettype wire

@@ hdl/joint_friction_observer_core.sv @@
// Joint friction observer: one request transfer per joint sample gives one response
// transfer with the friction estimate, the filtered sensed torque and the ramp status.
// Items are handled one at a time; an in-range joint reads its state, runs the multiply
// steps and writes back (the last joint also advances the filter ramp), an out-of-range
// joint goes straight to the response with zero torques, and the next request can be
// accepted once the response goes valid. The pace is set by the single shared 33x33
// multiplier, used for seven products in turn, and the registered per-joint state ram read.
// The next request is taken while a finished response still waits; a further result
// holds in the engine until the waiting one transfers. Configuration must be written
// through the apb port only while the block is idle; the block does not enforce this.
`default_nettype none
module joint_friction_observer_core import jfo_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   jfo_req_if.sink          req_ch,
   jfo_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   cfg_type            cfg;
   ram_req_type        ram;
   logic [STATE_W-1:0] ram_rd_data;
   stat_type           stat;

   assign pready = 1'b1;

   jfo_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg_ff(cfg)
   );

   jfo_ram #(.WIDTH(STATE_W), .DEPTH(JOINT_COUNT)) u_ram (
      .clock(clock), .rd_en(ram.rd_en), .wr_en(ram.wr_en), .addr(ram.addr),
      .wr_data(ram.wr_data), .rd_data_ff(ram_rd_data)
   );

   jfo_engine u_engine (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .cfg(cfg),
      .ram(ram), .ram_rd_data(ram_rd_data), .stat(stat)
   );

   // one item in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while an item is in flight");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_ch.ready)
      else $error("ready while busy");

   a_ticks_write: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr[4:2] == REG_RAMP_TICKS
      |=> cfg.ramp_ticks == $past(pwdata[15:0]))
      else $error("ramp ticks write lost");

   a_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram.rd_en && ram.wr_en))
      else $error("ram read and write in one cycle");
endmodule
`default_nettype wire

@@ hdl/jfo_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module jfo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   rd_en,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   output      logic [WIDTH-1:0]                       rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end
endmodule
`default_nettype wire

@@ hdl/jfo_csr.sv @@
// apb configuration registers
`default_nettype none
module jfo_csr import jfo_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      cfg_type     cfg_ff
);
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx = paddr[4:2];
   assign wr  = psel & penable & pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_RATE_GAIN:  cfg_in.rate_error_gain      = pwdata[30:0];
            REG_POS_GAIN:   cfg_in.position_error_gain  = pwdata[30:0];
            REG_STEP_INERT: cfg_in.step_over_inertia    = pwdata[30:0];
            REG_TIME_STEP:  cfg_in.time_step            = pwdata[30:0];
            REG_ALPHA_STEP: cfg_in.friction_alpha_step  = pwdata[30:0];
            REG_ALPHA_FIN:  cfg_in.friction_alpha_final = pwdata[30:0];
            REG_TORQ_COEFF: cfg_in.torque_filter_coeff  = pwdata[30:0];
            REG_RAMP_TICKS: cfg_in.ramp_ticks           = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rate_error_gain: '0, position_error_gain: '0,
                     step_over_inertia: '0, time_step: '0,
                     friction_alpha_step: Q30_ONE, friction_alpha_final: Q30_ONE,
                     torque_filter_coeff: '0, ramp_ticks: 16'd8000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_RATE_GAIN:  prdata = {1'b0, cfg_ff.rate_error_gain};
         REG_POS_GAIN:   prdata = {1'b0, cfg_ff.position_error_gain};
         REG_STEP_INERT: prdata = {1'b0, cfg_ff.step_over_inertia};
         REG_TIME_STEP:  prdata = {1'b0, cfg_ff.time_step};
         REG_ALPHA_STEP: prdata = {1'b0, cfg_ff.friction_alpha_step};
         REG_ALPHA_FIN:  prdata = {1'b0, cfg_ff.friction_alpha_final};
         REG_TORQ_COEFF: prdata = {1'b0, cfg_ff.torque_filter_coeff};
         REG_RAMP_TICKS: prdata = {16'd0, cfg_ff.ramp_ticks};
         default:        prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

@@ hdl/jfo_engine.sv @@
// sequencer and shared-multiplier datapath over the per-joint state memory
`default_nettype none
module jfo_engine import jfo_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   jfo_req_if.sink                  req,
   jfo_rsp_if.source                rsp,
   input  wire cfg_type             cfg,
   output      ram_req_type         ram,
   input  wire logic [STATE_W-1:0]  ram_rd_data,
   output      stat_type            stat
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_RD   = 5'd1,  S_LD   = 5'd2,  S_M1  = 5'd3,
                          S_M2   = 5'd4,  S_M3   = 5'd5,  S_M4   = 5'd6,  S_M5  = 5'd7,
                          S_M6   = 5'd8,  S_M7   = 5'd9,  S_M8   = 5'd10, S_M9  = 5'd11,
                          S_M10  = 5'd12, S_M11  = 5'd13, S_RMUL = 5'd14, S_RUPD = 5'd15,
                          S_DONE = 5'd16;

   logic [4:0]  state_ff, state_in;
   logic [2:0]  j_ff, j_in;
   logic        oor_ff, oor_in;
   logic        rs_ff, rs_in;
   logic signed [31:0] ang_ff, ang_in, vel_ff, vel_in, cmd_ff, cmd_in, sens_ff, sens_in;
   logic signed [31:0] na0_ff, na0_in, nv0_ff, nv0_in, lf_ff, lf_in, lt_ff, lt_in;
   logic signed [31:0] ev_ff, ev_in, ep_ff, ep_in, sigma_ff, sigma_in;
   logic signed [31:0] tauf_ff, tauf_in, taul_ff, taul_in, acc_ff, acc_in, nv_ff, nv_in;
   logic signed [31:0] na_ff, na_in;
   logic signed [65:0] sum_ff, sum_in, prod_ff, prod_in;
   logic [30:0] alpha_ff, alpha_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [JOINT_COUNT-1:0] vld_ff, vld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  oj_ff, oj_in;
   logic signed [31:0] of_ff, of_in, ot_ff, ot_in;
   logic        od_ff, od_in;

   logic [30:0] mul_a;
   logic signed [32:0] mul_b;
   logic [JIDX_W-1:0] addr;
   logic signed [65:0] rnd_v;
   logic [30:0] fin, anew;
   logic        acc_req;

   assign addr      = JIDX_W'(j_ff);
   assign fin       = clamp_q30(cfg.friction_alpha_final);
   assign req.ready = (state_ff == S_IDLE);
   assign acc_req   = req.valid & req.ready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M1:   begin mul_a = cfg.rate_error_gain;     mul_b = 33'(ev_ff); end
         S_M2:   begin mul_a = cfg.position_error_gain; mul_b = 33'(ep_ff); end
         S_M4:   begin mul_a = alpha_ff; mul_b = 33'(lf_ff) - 33'(sigma_ff); end
         S_M5:   begin
            mul_a = clamp_q30(cfg.torque_filter_coeff);
            mul_b = 33'(lt_ff) - 33'(sens_ff);
         end
         S_M8:   begin mul_a = cfg.step_over_inertia; mul_b = 33'(acc_ff); end
         S_M10:  begin mul_a = cfg.time_step;         mul_b = 33'(nv_ff); end
         S_RMUL: begin
            mul_a = clamp_q30(cfg.friction_alpha_step);
            mul_b = $signed({2'b00, alpha_ff});
         end
         default: ;
      endcase
   end
   assign prod_in = $signed({2'b00, mul_a}) * mul_b;
   assign rnd_v   = rnd30(prod_ff);
   assign anew    = (rnd_v[30:0] < fin) ? fin : rnd_v[30:0];

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;
      j_in = j_ff; oor_in = oor_ff; rs_in = rs_ff;
      ang_in = ang_ff; vel_in = vel_ff; cmd_in = cmd_ff; sens_in = sens_ff;
      na0_in = na0_ff; nv0_in = nv0_ff; lf_in = lf_ff; lt_in = lt_ff;
      ev_in = ev_ff; ep_in = ep_ff; sigma_in = sigma_ff; sum_in = sum_ff;
      tauf_in = tauf_ff; taul_in = taul_ff; acc_in = acc_ff; nv_in = nv_ff; na_in = na_ff;
      alpha_in = alpha_ff; phase_in = phase_ff; count_in = count_ff; vld_in = vld_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      oj_in = oj_ff; of_in = of_ff; ot_in = ot_ff; od_in = od_ff;
      ram = '{rd_en: 1'b0, wr_en: 1'b0, addr: addr,
              wr_data: {na_ff, nv_ff, tauf_ff, taul_ff}};
      unique case (state_ff)
         S_IDLE: begin
            if (acc_req) begin
               j_in = req.joint_index; rs_in = req.resync;
               ang_in = req.measured_angle; vel_in = req.measured_velocity;
               cmd_in = req.commanded_torque; sens_in = req.sensed_torque;
               oor_in = (4'(req.joint_index) >= 4'(JOINT_COUNT));
               if (oor_in) begin
                  tauf_in = '0; taul_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            ram.rd_en = 1'b1;
            state_in = S_LD;
         end
         // load state, apply resync, form errors
         S_LD: begin
            if (vld_ff[addr]) begin
               {na0_in, nv0_in, lf_in, lt_in} = ram_rd_data;
            end else begin
               {na0_in, nv0_in, lf_in, lt_in} = '0;
            end
            if (rs_ff) begin
               na0_in = ang_ff; nv0_in = vel_ff; lf_in = '0; lt_in = '0;
               phase_in = PH_IDLE; count_in = '0; alpha_in = Q30_ONE;
            end
            ev_in = sat32(sx66(nv0_in) - sx66(vel_ff));
            ep_in = sat32(sx66(na0_in) - sx66(ang_ff));
            state_in = S_M1;
         end
         S_M1: state_in = S_M2;
         S_M2: begin
            sum_in = prod_ff;
            state_in = S_M3;
         end
         // pd correction
         S_M3: begin
            sigma_in = sat32(-rnd16(sum_ff + prod_ff));
            state_in = S_M4;
         end
         S_M4: state_in = S_M5;
         S_M5: begin
            tauf_in = sat32(sx66(sigma_ff) + rnd_v);
            state_in = S_M6;
         end
         S_M6: begin
            taul_in = sat32(sx66(sens_ff) + rnd_v);
            state_in = S_M7;
         end
         S_M7: begin
            acc_in = sat32(sx66(cmd_ff) - sx66(taul_ff) + sx66(sigma_ff) - sx66(tauf_ff));
            state_in = S_M8;
         end
         S_M8: state_in = S_M9;
         S_M9: begin
            nv_in = sat32(sx66(nv0_ff) + rnd_v);
            state_in = S_M10;
         end
         S_M10: state_in = S_M11;
         // euler angle update and write back
         S_M11: begin
            na_in = sat32(sx66(na0_ff) + rnd_v);
            ram.wr_en = 1'b1;
            ram.wr_data = {na_in, nv_ff, tauf_ff, taul_ff};
            vld_in[addr] = 1'b1;
            state_in = (4'(j_ff) == 4'(JOINT_COUNT - 1)) ? S_RMUL : S_DONE;
         end
         S_RMUL: state_in = S_RUPD;
         // ramp advance once per tick
         S_RUPD: begin
            if (phase_ff == PH_IDLE) begin
               count_in = '0;
               if (cfg.ramp_ticks == '0) begin
                  alpha_in = fin; phase_in = PH_DONE;
               end else begin
                  phase_in = PH_RAMP;
               end
            end else if (phase_ff == PH_RAMP) begin
               alpha_in = anew;
               count_in = count_ff + 16'd1;
               if (count_in >= cfg.ramp_ticks) begin
                  alpha_in = fin; phase_in = PH_DONE;
               end
            end else begin
               alpha_in = fin;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               oj_in = j_ff; of_in = tauf_ff; ot_in = taul_ff;
               od_in = (phase_ff == PH_DONE);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         alpha_ff <= Q30_ONE;
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         alpha_ff <= alpha_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         vld_ff <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff <= j_in; oor_ff <= oor_in; rs_ff <= rs_in;
      ang_ff <= ang_in; vel_ff <= vel_in; cmd_ff <= cmd_in; sens_ff <= sens_in;
      na0_ff <= na0_in; nv0_ff <= nv0_in; lf_ff <= lf_in; lt_ff <= lt_in;
      ev_ff <= ev_in; ep_ff <= ep_in; sigma_ff <= sigma_in; sum_ff <= sum_in;
      prod_ff <= prod_in;
      tauf_ff <= tauf_in; taul_ff <= taul_in; acc_ff <= acc_in; nv_ff <= nv_in;
      na_ff <= na_in;
      oj_ff <= oj_in; of_ff <= of_in; ot_ff <= ot_in; od_ff <= od_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.joint_echo      = oj_ff;
   assign rsp.friction_torque = of_ff;
   assign rsp.filtered_torque = ot_ff;
   assign rsp.ramp_done       = od_ff;
   assign stat.busy           = (state_ff != S_IDLE);
   assign stat.ramp_phase     = phase_ff;
endmodule
`default_nettype wire
